FILE: rtl/dpd_pkg.sv
// Shared types, constants and calendar helpers for the date_plus_days unit.
// No dependencies; imported by dpd_ctrl, dpd_datapath and date_plus_days_unit.
package dpd_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int ADD_W = 22;
	localparam int WORK_YEAR_W = 15;
	localparam int OFF_W = 23;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 24;

	localparam logic [WORK_YEAR_W-1:0] YEAR_LIMIT = 15'd10000;
	localparam logic [WORK_YEAR_W-1:0] CYCLE_YEARS = 15'd400;
	localparam logic [OFF_W-1:0] CYCLE_DAYS = 23'd146097;
	localparam logic [YEAR_W-1:0] REM_MOD = 14'd400;
	localparam logic [YEAR_W-1:0] REM_LAST = 14'd399;
	localparam logic [MONTH_W-1:0] MONTHS = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CLAMP,
		ST_SUM,
		ST_CYC,
		ST_YEAR,
		ST_MON,
		ST_FIN
	} dpd_state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic clamp;
		logic sum_step;
		logic cyc_step;
		logic year_step;
		logic mon_init;
		logic mon_step;
		logic finish;
	} dpd_cmd_t;

	typedef struct packed {
		logic rem_ge;
		logic k_lt_m;
		logic off_ge_cyc;
		logic off_ge_year;
		logic mon_more;
		logic out_free;
	} dpd_status_t;

	// leap test on the year taken modulo 400
	function automatic logic leap_of(input logic [8:0] rem);
		return (rem[1:0] == 2'd0) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (m) inside
			MONTH_FEB: n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/date_plus_days_unit.sv
// Top level of the Gregorian date-plus-days unit.
// Depends on dpd_pkg, dpd_ctrl and dpd_datapath.
//
//  group | dir | tdata (low bit up)                       | tuser
//  s_*   | in  | year, month, day, day count               | -
//  m_*   | out | year, month, day                          | out_of_range
//
// Each transfer walks in steps: the year is reduced modulo 400, the day is clamped, the
// lengths of the months before the start month are summed, whole 400-year cycles are
// stripped from the offset, then the remaining years (up to 399) and months (up to 11).
// Reset clears the sequencer and the output valid; the result register holds one result,
// and the walk waits in its last step while that result is not yet taken.
module date_plus_days_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // year, month, day, day count, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // year, month, day, zero pad
	output logic        m_tuser   // out_of_range
);
	import dpd_pkg::*;

	dpd_cmd_t          cmd;
	dpd_status_t       st;
	logic [YEAR_W-1:0]  res_year;
	logic [MONTH_W-1:0] res_month;
	logic [DAY_W-1:0]   res_day;

	dpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	dpd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_year   (s_tdata[13:0]),
		.in_month  (s_tdata[17:14]),
		.in_day    (s_tdata[22:18]),
		.in_add    (s_tdata[44:23]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_year  (res_year),
		.out_month (res_month),
		.out_day   (res_day),
		.out_range (m_tuser)
	);

	assign m_tdata = {1'b0, res_day, res_month, res_year};

endmodule

FILE: rtl/dpd_ctrl.sv
// Sequencer for the date walk: issues at most one datapath command per cycle.
// Depends on dpd_pkg.
module dpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dpd_pkg::dpd_status_t st,
	output dpd_pkg::dpd_cmd_t    cmd
);
	import dpd_pkg::*;

	dpd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (st.rem_ge) begin
					cmd.mod_step = 1'b1;
				end else begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (st.k_lt_m) begin
					cmd.sum_step = 1'b1;
				end else begin
					state_d = ST_CYC;
				end
			end
			ST_CYC: begin
				if (st.off_ge_cyc) begin
					cmd.cyc_step = 1'b1;
				end else begin
					state_d = ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (st.off_ge_year) begin
					cmd.year_step = 1'b1;
				end else begin
					cmd.mon_init = 1'b1;
					state_d = ST_MON;
				end
			end
			ST_MON: begin
				if (st.mon_more) begin
					cmd.mon_step = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("result overwrites an untaken result");
`endif

endmodule

FILE: rtl/dpd_datapath.sv
// Date registers, calendar arithmetic and the output register.
// Depends on dpd_pkg; driven by dpd_ctrl.
module dpd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpd_pkg::dpd_cmd_t            cmd,
	output dpd_pkg::dpd_status_t         st,
	input  logic [dpd_pkg::YEAR_W-1:0]   in_year,
	input  logic [dpd_pkg::MONTH_W-1:0]  in_month,
	input  logic [dpd_pkg::DAY_W-1:0]    in_day,
	input  logic [dpd_pkg::ADD_W-1:0]    in_add,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dpd_pkg::YEAR_W-1:0]   out_year,
	output logic [dpd_pkg::MONTH_W-1:0]  out_month,
	output logic [dpd_pkg::DAY_W-1:0]    out_day,
	output logic                         out_range
);
	import dpd_pkg::*;

	logic [WORK_YEAR_W-1:0] year_q;
	logic [YEAR_W-1:0]      rem_q;
	logic [MONTH_W-1:0]     m_q;
	logic [MONTH_W-1:0]     k_q;
	logic [DAY_W-1:0]       d_q;
	logic [ADD_W-1:0]       add_q;
	logic [OFF_W-1:0]       off_q;

	logic                   leap;
	logic [MONTH_W-1:0]     m_clamp;
	logic [DAY_W-1:0]       d_lim;
	logic [DAY_W-1:0]       d_clamp;
	logic [DAY_W-1:0]       k_len;
	logic [DAY_W-1:0]       m_len;
	logic [OFF_W-1:0]       year_len;
	logic                   over;

	assign leap = leap_of(rem_q[8:0]);
	assign m_clamp = (in_month == '0) ? 4'd1 : ((in_month > MONTHS) ? MONTHS : in_month);
	assign d_lim = month_len(m_q, leap);
	always_comb begin
		d_clamp = (d_q == '0) ? 5'd1 : d_q;
		if (d_clamp > d_lim) begin
			d_clamp = d_lim;
		end
	end
	assign k_len = month_len(k_q, leap);
	assign m_len = month_len(m_q, leap);
	assign year_len = leap ? 23'd366 : 23'd365;
	assign over = (year_q >= YEAR_LIMIT);

	assign st.rem_ge = (rem_q >= REM_MOD);
	assign st.k_lt_m = (k_q < m_q);
	assign st.off_ge_cyc = (off_q >= CYCLE_DAYS);
	assign st.off_ge_year = (off_q >= year_len);
	assign st.mon_more = (m_q < MONTHS) && (off_q >= OFF_W'(m_len));
	assign st.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= WORK_YEAR_W'(in_year);
			rem_q <= in_year;
			m_q <= m_clamp;
			d_q <= in_day;
			add_q <= in_add;
		end
		if (cmd.mod_step) begin
			rem_q <= rem_q - REM_MOD;
		end
		if (cmd.clamp) begin
			off_q <= OFF_W'(add_q) + OFF_W'(d_clamp) - 23'd1;
			k_q <= 4'd1;
		end
		if (cmd.sum_step) begin
			off_q <= off_q + OFF_W'(k_len);
			k_q <= k_q + 4'd1;
		end
		if (cmd.cyc_step) begin
			off_q <= off_q - CYCLE_DAYS;
			year_q <= year_q + CYCLE_YEARS;
		end
		if (cmd.year_step) begin
			off_q <= off_q - year_len;
			year_q <= year_q + 15'd1;
			rem_q <= (rem_q == REM_LAST) ? '0 : rem_q + 14'd1;
		end
		if (cmd.mon_init) begin
			m_q <= 4'd1;
		end
		if (cmd.mon_step) begin
			off_q <= off_q - OFF_W'(m_len);
			m_q <= m_q + 4'd1;
		end
		if (cmd.finish) begin
			out_year <= over ? '0 : year_q[YEAR_W-1:0];
			out_month <= over ? '0 : m_q;
			out_day <= over ? '0 : off_q[DAY_W-1:0] + 5'd1;
			out_range <= over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

`ifndef SYNTH
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clamp |-> (rem_q < REM_MOD))
		else $error("year remainder not reduced before clamp");
	a_mon_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mon_step |-> (m_q < MONTHS))
		else $error("month walk beyond December");
`endif

endmodule
